// ----- hdl/ecc_pkg.sv -----
// Shared types, codes and a helper function of the Euler circuit checker.
`timescale 1ns / 1ps
package ecc_pkg;
   localparam int VSLOTS = 64;
   localparam int VW     = 6;
   localparam int CNTW   = 7;
   localparam int BALW   = 12;

   localparam logic [1:0] KIND_EDGE  = 2'd0;
   localparam logic [1:0] KIND_CHECK = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic CSR_DIRECTED = 1'b0;
   localparam logic CSR_VCOUNT   = 1'b1;

   typedef struct packed {
      logic                adj_we;
      logic [VW-1:0]       adj_addr;
      logic [VSLOTS-1:0]   adj_data;
      logic                bal_we;
      logic [VW-1:0]       bal_addr;
      logic [BALW-1:0]     bal_data;
      logic                clear;
   } store_wr_type;

   // Index of the lowest set bit; zero for an empty word.
   function automatic logic [VW-1:0] lowest_bit(input logic [VSLOTS-1:0] word);
      logic [VW-1:0] idx;
      idx = '0;
      for (int i = VSLOTS - 1; i >= 0; i--) begin
         if (word[i]) idx = VW'(i);
      end
      return idx;
   endfunction
endpackage

// ----- hdl/ecc_req_if.sv -----
// Request and response channel interfaces of the Euler circuit checker.
`timescale 1ns / 1ps
interface ecc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [5:0] from_vertex;
   logic [5:0] to_vertex;
   modport source (output valid, kind, from_vertex, to_vertex, input ready);
   modport sink (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

interface ecc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       verdict_valid;
   logic       is_eulerian;
   logic       is_connected;
   logic       degrees_ok;
   modport source (output valid, status, verdict_valid, is_eulerian, is_connected,
                   degrees_ok, input ready);
   modport sink (input valid, status, verdict_valid, is_eulerian, is_connected,
                 degrees_ok, output ready);
endinterface

// ----- hdl/ecc_graph_store.sv -----
// Adjacency and degree balance memories with per-entry valid bits.
`timescale 1ns / 1ps
module ecc_graph_store
   import ecc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  store_wr_type        wr,
   input  logic [VW-1:0]       rd_addr,
   output logic [VSLOTS-1:0]   adj_row,
   output logic [BALW-1:0]     bal_val
);
   logic [VSLOTS-1:0] adj_mem_ff [VSLOTS];
   logic [BALW-1:0]   bal_mem_ff [VSLOTS];
   logic [VSLOTS-1:0] adj_q_ff;
   logic [BALW-1:0]   bal_q_ff;
   logic [VW-1:0]     addr_ff;
   logic [VSLOTS-1:0] adj_vld_ff, adj_vld_in;
   logic [VSLOTS-1:0] bal_vld_ff, bal_vld_in;

   always_ff @(posedge clock) begin
      if (wr.adj_we) adj_mem_ff[wr.adj_addr] <= wr.adj_data;
      if (wr.bal_we) bal_mem_ff[wr.bal_addr] <= wr.bal_data;
      adj_q_ff <= adj_mem_ff[rd_addr];
      bal_q_ff <= bal_mem_ff[rd_addr];
      addr_ff  <= rd_addr;
   end

   // An entry that was never written since the last clear reads as zero.
   always_comb begin
      adj_vld_in = adj_vld_ff;
      bal_vld_in = bal_vld_ff;
      if (wr.clear) begin
         adj_vld_in = '0;
         bal_vld_in = '0;
      end else begin
         if (wr.adj_we) adj_vld_in[wr.adj_addr] = 1'b1;
         if (wr.bal_we) bal_vld_in[wr.bal_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_vld_ff <= '0;
         bal_vld_ff <= '0;
      end else begin
         adj_vld_ff <= adj_vld_in;
         bal_vld_ff <= bal_vld_in;
      end
   end

   assign adj_row = adj_vld_ff[addr_ff] ? adj_q_ff : '0;
   assign bal_val = bal_vld_ff[addr_ff] ? bal_q_ff : '0;
endmodule

// ----- hdl/euler_circuit_checker_top.sv -----
// Top level of the Euler circuit checker: control sequencer, walk stack and result register.
//
//   channel  dir  handshake          word
//   req      in   req.valid/ready    kind, from_vertex, to_vertex
//   rsp      out  rsp.valid/ready    status, verdict_valid, is_eulerian,
//                                    is_connected, degrees_ok
//   csr      in   csr_we             csr_index, csr_wdata
//
// A clear, a spare kind or a rejected edge is answered straight from the idle state; an accepted
// edge first passes EDGE_U and EDGE_V, the read-modify-write of both endpoints through one memory
// port. A check scans all in-use vertices in SCAN and TEST; if one has edges, it walks depth-first
// from WINIT through POP, ROW and FRESH per popped vertex and PUSH per pushed vertex, then DONE.
// One word is in flight at a time; a new request is taken once the previous response
// has left the output register. Reset is synchronous and clears the graph and control state.
`timescale 1ns / 1ps
module euler_circuit_checker_top
   import ecc_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 1024
) (
   input  logic            clock,
   input  logic            reset,
   ecc_req_if.sink         req,
   ecc_rsp_if.source       rsp,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [CNTW-1:0] csr_wdata
);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int LIVE_LIM = (MAX_VERTICES < VSLOTS) ? MAX_VERTICES : VSLOTS;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_EDGE_U  = 4'd1;
   localparam logic [3:0] ST_EDGE_V  = 4'd2;
   localparam logic [3:0] ST_SCAN    = 4'd3;
   localparam logic [3:0] ST_TEST    = 4'd4;
   localparam logic [3:0] ST_WINIT   = 4'd5;
   localparam logic [3:0] ST_POP     = 4'd6;
   localparam logic [3:0] ST_ROW     = 4'd7;
   localparam logic [3:0] ST_FRESH   = 4'd8;
   localparam logic [3:0] ST_PUSH    = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic              directed_ff, directed_in;
   logic [CNTW-1:0]   vcount_ff, vcount_in;
   logic [VW-1:0]     u_ff, u_in, v_ff, v_in;
   logic              dir_ff, dir_in;
   logic [CNTW-1:0]   idx_ff, idx_in;
   logic [VW-1:0]     start_ff, start_in;
   logic              found_ff, found_in;
   logic              degok_ff, degok_in;
   logic [VSLOTS-1:0] visited_ff, visited_in;
   logic [VSLOTS-1:0] fresh_ff, fresh_in;
   logic [CNTW-1:0]   sp_ff, sp_in;
   logic [VSLOTS-1:0] fwd_adj_ff, fwd_adj_in;
   logic [BALW-1:0]   fwd_bal_ff, fwd_bal_in;
   logic [VSLOTS-1:0] has_edges_ff, has_edges_in;
   logic [ECW-1:0]    edge_total_ff, edge_total_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_verdict_ff, rsp_verdict_in;
   logic              rsp_conn_ff, rsp_conn_in;
   logic              rsp_degok_ff, rsp_degok_in;

   logic [VW-1:0]     stk_mem_ff [VSLOTS];
   logic [VW-1:0]     stk_q_ff;
   logic [VW-1:0]     stk_rd_addr;
   logic              stk_we;
   logic [VW-1:0]     stk_wr_addr;
   logic [VW-1:0]     stk_wr_data;

   store_wr_type      st_wr;
   logic [VW-1:0]     rd_addr;
   logic [VSLOTS-1:0] adj_row;
   logic [BALW-1:0]   bal_val;

   logic [CNTW-1:0]   live_n;
   logic [VSLOTS-1:0] live_mask;
   logic              accept;
   logic [VSLOTS-1:0] base_adj;
   logic [BALW-1:0]   base_bal;
   logic [VW-1:0]     push_idx;
   logic [CNTW-1:0]   sp_dec;

   ecc_graph_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (st_wr),
      .rd_addr (rd_addr),
      .adj_row (adj_row),
      .bal_val (bal_val)
   );

   // Vertex count saturates to the number of vertex slots the build supports.
   assign live_n = (vcount_ff > CNTW'(LIVE_LIM)) ? CNTW'(LIVE_LIM) : vcount_ff;
   assign live_mask = (live_n >= CNTW'(VSLOTS)) ? '1
                    : ((VSLOTS'(1) << live_n) - VSLOTS'(1));

   assign req.ready = (state_ff == ST_IDLE) && !rsp_vld_ff;
   assign accept    = req.valid && req.ready;

   // The second endpoint of a self-loop sees the value just written for the first.
   assign base_adj = (u_ff == v_ff) ? fwd_adj_ff : adj_row;
   assign base_bal = (u_ff == v_ff) ? fwd_bal_ff : bal_val;
   assign push_idx = lowest_bit(fresh_ff);
   assign sp_dec   = sp_ff - CNTW'(1);

   always_comb begin
      state_in       = state_ff;
      directed_in    = directed_ff;
      vcount_in      = vcount_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      dir_in         = dir_ff;
      idx_in         = idx_ff;
      start_in       = start_ff;
      found_in       = found_ff;
      degok_in       = degok_ff;
      visited_in     = visited_ff;
      fresh_in       = fresh_ff;
      sp_in          = sp_ff;
      fwd_adj_in     = fwd_adj_ff;
      fwd_bal_in     = fwd_bal_ff;
      has_edges_in   = has_edges_ff;
      edge_total_in  = edge_total_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_conn_in    = rsp_conn_ff;
      rsp_degok_in   = rsp_degok_ff;
      st_wr          = '0;
      rd_addr        = u_ff;
      stk_rd_addr    = sp_dec[VW-1:0];
      stk_we         = 1'b0;
      stk_wr_addr    = sp_ff[VW-1:0];
      stk_wr_data    = push_idx;

      if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTED: directed_in = csr_wdata[0];
            CSR_VCOUNT:   vcount_in   = csr_wdata;
            default:      vcount_in   = vcount_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req.from_vertex;
            if (accept) begin
               u_in           = req.from_vertex;
               v_in           = req.to_vertex;
               dir_in         = directed_ff;
               rsp_status_in  = STAT_OK;
               rsp_verdict_in = 1'b0;
               rsp_conn_in    = 1'b0;
               rsp_degok_in   = 1'b0;
               priority case (req.kind)
                  KIND_EDGE: begin
                     if ({1'b0, req.from_vertex} >= live_n
                         || {1'b0, req.to_vertex} >= live_n) begin
                        rsp_status_in = STAT_RANGE;
                        rsp_vld_in    = 1'b1;
                     end else if (edge_total_ff >= ECW'(MAX_EDGES)) begin
                        rsp_status_in = STAT_FULL;
                        rsp_vld_in    = 1'b1;
                     end else begin
                        state_in = ST_EDGE_U;
                     end
                  end
                  KIND_CHECK: begin
                     idx_in     = '0;
                     found_in   = 1'b0;
                     degok_in   = 1'b1;
                     visited_in = '0;
                     state_in   = ST_SCAN;
                  end
                  KIND_CLEAR: begin
                     st_wr.clear   = 1'b1;
                     has_edges_in  = '0;
                     edge_total_in = '0;
                     rsp_vld_in    = 1'b1;
                  end
                  default: rsp_vld_in = 1'b1;
               endcase
            end
         end
         ST_EDGE_U: begin
            fwd_adj_in     = adj_row | (VSLOTS'(1) << v_ff);
            fwd_bal_in     = bal_val + BALW'(1);
            st_wr.adj_we   = 1'b1;
            st_wr.adj_addr = u_ff;
            st_wr.adj_data = fwd_adj_in;
            st_wr.bal_we   = 1'b1;
            st_wr.bal_addr = u_ff;
            st_wr.bal_data = fwd_bal_in;
            rd_addr        = v_ff;
            state_in       = ST_EDGE_V;
         end
         ST_EDGE_V: begin
            st_wr.bal_we   = 1'b1;
            st_wr.bal_addr = v_ff;
            st_wr.bal_data = dir_ff ? (base_bal - BALW'(1)) : (base_bal + BALW'(1));
            st_wr.adj_we   = !dir_ff;
            st_wr.adj_addr = v_ff;
            st_wr.adj_data = base_adj | (VSLOTS'(1) << u_ff);
            has_edges_in   = has_edges_ff | (VSLOTS'(1) << u_ff) | (VSLOTS'(1) << v_ff);
            edge_total_in  = edge_total_ff + ECW'(1);
            rsp_vld_in     = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            rd_addr = idx_ff[VW-1:0];
            if (idx_ff < live_n) begin
               state_in = ST_TEST;
            end else if (found_ff) begin
               state_in = ST_WINIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TEST: begin
            rd_addr = idx_ff[VW-1:0];
            if (directed_ff ? (bal_val != '0) : bal_val[0]) degok_in = 1'b0;
            if (!found_ff && ((adj_row & live_mask) != '0)) begin
               found_in = 1'b1;
               start_in = idx_ff[VW-1:0];
            end
            idx_in   = idx_ff + CNTW'(1);
            state_in = ST_SCAN;
         end
         ST_WINIT: begin
            visited_in  = VSLOTS'(1) << start_ff;
            stk_we      = 1'b1;
            stk_wr_addr = '0;
            stk_wr_data = start_ff;
            sp_in       = CNTW'(1);
            state_in    = ST_POP;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               sp_in    = sp_dec;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            rd_addr  = stk_q_ff;
            state_in = ST_FRESH;
         end
         ST_FRESH: begin
            fresh_in   = adj_row & live_mask & ~visited_ff;
            visited_in = visited_ff | fresh_in;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (fresh_ff == '0) begin
               state_in = ST_POP;
            end else begin
               stk_we   = 1'b1;
               sp_in    = sp_ff + CNTW'(1);
               fresh_in = fresh_ff & ~(VSLOTS'(1) << push_idx);
            end
         end
         ST_DONE: begin
            rsp_verdict_in = 1'b1;
            rsp_conn_in    = ((has_edges_ff & live_mask & ~visited_ff) == '0);
            rsp_degok_in   = degok_ff;
            rsp_vld_in     = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem_ff[stk_wr_addr] <= stk_wr_data;
      stk_q_ff <= stk_mem_ff[stk_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         directed_ff   <= 1'b0;
         vcount_ff     <= CNTW'(VSLOTS);
         has_edges_ff  <= '0;
         edge_total_ff <= '0;
         rsp_vld_ff    <= 1'b0;
         sp_ff         <= '0;
         found_ff      <= 1'b0;
         degok_ff      <= 1'b1;
         visited_ff    <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         directed_ff   <= directed_in;
         vcount_ff     <= vcount_in;
         has_edges_ff  <= has_edges_in;
         edge_total_ff <= edge_total_in;
         rsp_vld_ff    <= rsp_vld_in;
         sp_ff         <= sp_in;
         found_ff      <= found_in;
         degok_ff      <= degok_in;
         visited_ff    <= visited_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff           <= u_in;
      v_ff           <= v_in;
      dir_ff         <= dir_in;
      start_ff       <= start_in;
      fresh_ff       <= fresh_in;
      fwd_adj_ff     <= fwd_adj_in;
      fwd_bal_ff     <= fwd_bal_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_conn_ff    <= rsp_conn_in;
      rsp_degok_ff   <= rsp_degok_in;
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.verdict_valid = rsp_verdict_ff;
   assign rsp.is_connected  = rsp_conn_ff;
   assign rsp.degrees_ok    = rsp_degok_ff;
   assign rsp.is_eulerian   = rsp_conn_ff && rsp_degok_ff;

`ifndef SYNTHESIS
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNTW'(VSLOTS))
      else $error("walk stack pointer beyond depth");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && fresh_ff != '0) |-> sp_ff < CNTW'(VSLOTS))
      else $error("push into a full walk stack");
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= ECW'(MAX_EDGES))
      else $error("edge count above limit");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_vld_ff)
      else $error("response pending while an item is in progress");
   a_verdict_only_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_verdict_ff) |-> (!rsp_conn_ff && !rsp_degok_ff))
      else $error("verdict bits set on a non-check response");
`endif
endmodule

// ----- tb/sv/tb.sv -----
// Testbench of the Euler circuit checker: directed and random words with a scoreboard.
`timescale 1ns / 1ps
module tb
   import ecc_pkg::*;
();

   // Kind code that the block answers without any effect.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // One expected response word.
   typedef struct {
      logic [1:0] status;
      logic       verdict_valid;
      logic       is_eulerian;
      logic       is_connected;
      logic       degrees_ok;
   } verdict_type;

   // Scoreboard: it keeps its own copy of the graph and predicts every response word.
   class euler_scoreboard;
      logic [63:0] adj[64];
      logic [11:0] bal[64];
      logic [63:0] touched;
      int          edges;
      logic        directed;
      logic [6:0]  vcount;
      verdict_type pending[$];
      int          errors;

      function void wipe();
         for (int i = 0; i < 64; i++) begin
            adj[i] = '0;
            bal[i] = '0;
         end
         touched = '0;
         edges = 0;
      endfunction

      function void write_reg(logic idx, logic [6:0] val);
         if (idx == CSR_DIRECTED) directed = val[0];
         else vcount = val;
      endfunction

      // Works out the response of one accepted request word.
      function void note_request(logic [1:0] kind, logic [5:0] u, logic [5:0] v);
         verdict_type r;
         int          n;
         logic [63:0] mask, seen, fresh;
         int          stack[$];
         int          x;
         n = (vcount > 64) ? 64 : vcount;
         mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
         r = '{STAT_OK, 1'b0, 1'b0, 1'b0, 1'b0};
         if (kind == KIND_EDGE) begin
            if (u >= n || v >= n) r.status = STAT_RANGE;
            else if (edges >= 1024) r.status = STAT_FULL;
            else begin
               edges++;
               adj[u][v] = 1'b1;
               touched[u] = 1'b1;
               touched[v] = 1'b1;
               bal[u] = bal[u] + 12'd1;
               if (directed) bal[v] = bal[v] - 12'd1;
               else begin
                  adj[v][u] = 1'b1;
                  bal[v] = bal[v] + 12'd1;
               end
            end
         end else if (kind == KIND_CHECK) begin
            seen = '0;
            for (int i = 0; i < n; i++) begin
               if ((adj[i] & mask) != 0) begin
                  seen[i] = 1'b1;
                  stack = {stack, i};
                  break;
               end
            end
            while (stack.size() > 0) begin
               x = stack.pop_back();
               fresh = adj[x] & mask & ~seen;
               for (int i = 0; i < 64; i++) begin
                  if (fresh[i]) begin
                     seen[i] = 1'b1;
                     stack = {stack, i};
                  end
               end
            end
            r.verdict_valid = 1'b1;
            r.is_connected = ((touched & mask & ~seen) == 0);
            r.degrees_ok = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (directed ? (bal[i] != 0) : bal[i][0]) r.degrees_ok = 1'b0;
            end
            r.is_eulerian = r.is_connected & r.degrees_ok;
         end else if (kind == KIND_CLEAR) begin
            wipe();
         end
         pending = {pending, r};
      endfunction

      function void check_response(verdict_type got);
         verdict_type w;
         if (pending.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.status !== w.status) begin
            $error("status expected %0d actual %0d", w.status, got.status);
            errors++;
         end
         if (got.verdict_valid !== w.verdict_valid) begin
            $error("verdict_valid expected %0d actual %0d", w.verdict_valid,
                   got.verdict_valid);
            errors++;
         end
         if (got.is_eulerian !== w.is_eulerian) begin
            $error("is_eulerian expected %0d actual %0d", w.is_eulerian, got.is_eulerian);
            errors++;
         end
         if (got.is_connected !== w.is_connected) begin
            $error("is_connected expected %0d actual %0d", w.is_connected,
                   got.is_connected);
            errors++;
         end
         if (got.degrees_ok !== w.degrees_ok) begin
            $error("degrees_ok expected %0d actual %0d", w.degrees_ok, got.degrees_ok);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_wdata = '0;
   int         cycle_count = 0;
   bit         stim_done = 0;

   ecc_req_if req ();
   ecc_rsp_if rsp ();

   euler_scoreboard board;

   euler_circuit_checker_top DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_EDGE;
      req.from_vertex = '0;
      req.to_vertex = '0;
      rsp.ready = 1'b0;
      board = new();
      board.wipe();
      board.directed = 1'b0;
      board.vcount = 7'd64;
      board.errors = 0;
   end

   // Watchdog: ends the run as failed once the cycle counter passes its bound.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: draws a stall per word and checks every accepted word.
   initial begin
      int stall;
      verdict_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got = '{rsp.status, rsp.verdict_valid, rsp.is_eulerian, rsp.is_connected,
                 rsp.degrees_ok};
         board.check_response(got);
      end
   end

   // Sends one request word after a random gap; burst mode skips the gap.
   task automatic send_word(logic [1:0] kind, logic [5:0] u, logic [5:0] v,
                            bit burst = 0);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      repeat (gap) @(posedge clock);
      req.valid <= 1'b1;
      req.kind <= kind;
      req.from_vertex <= u;
      req.to_vertex <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(kind, u, v);
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected word has come back, then lets the block settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Registers are only written while the block is idle.
   task automatic write_csr(logic idx, logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // A closed walk through random vertices below n (repeats allowed), with its edges sent in order.
   task automatic send_ring(int n);
      int k, first, prev, nxt;
      k = $urandom_range(2, (n < 8) ? n : 8);
      first = $urandom_range(0, n - 1);
      prev = first;
      for (int i = 1; i < k; i++) begin
         nxt = $urandom_range(0, n - 1);
         send_word(KIND_EDGE, 6'(prev), 6'(nxt));
         prev = nxt;
      end
      send_word(KIND_EDGE, 6'(prev), 6'(first));
   endtask

   initial begin
      int n, pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty graph, extremes, self-loop, odd degree, range errors.
      send_word(KIND_CHECK, 6'd0, 6'd0);
      send_word(KIND_EDGE, 6'd0, 6'd63);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      send_word(KIND_EDGE, 6'd63, 6'd0);
      send_word(KIND_EDGE, 6'd5, 6'd5);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      send_word(KIND_EDGE, 6'd10, 6'd20);
      send_word(KIND_EDGE, 6'd20, 6'd10);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      send_word(KIND_SPARE, 6'd42, 6'd21);
      send_word(KIND_CLEAR, 6'd0, 6'd0);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      drain();
      write_csr(CSR_VCOUNT, 7'd8);
      write_csr(CSR_DIRECTED, 7'd1);
      send_word(KIND_EDGE, 6'd8, 6'd1);
      send_word(KIND_EDGE, 6'd1, 6'd63);
      send_word(KIND_EDGE, 6'd1, 6'd2);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      send_word(KIND_EDGE, 6'd2, 6'd1);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      drain();
      // Vertex count lowered after loading masks the higher vertices.
      write_csr(CSR_VCOUNT, 7'd2);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      drain();
      write_csr(CSR_VCOUNT, 7'd0);
      send_word(KIND_EDGE, 6'd0, 6'd0);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      drain();
      write_csr(CSR_VCOUNT, 7'd127);
      send_word(KIND_CLEAR, 6'd0, 6'd0);
      // A burst of random edges, sent without gaps.
      for (int i = 0; i < 40; i++)
         send_word(KIND_EDGE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1);
      send_word(KIND_CHECK, 6'd0, 6'd0);
      send_word(KIND_CLEAR, 6'd0, 6'd0);

      // Random part: mostly rings that make Euler graphs, then a check; some noise.
      for (int phase = 0; phase < 12; phase++) begin
         drain();
         write_csr(CSR_DIRECTED, 7'($urandom_range(0, 1)));
         pick = $urandom_range(0, 3);
         n = (pick == 0) ? 64 : (pick == 1) ? 1 : $urandom_range(2, 16);
         write_csr(CSR_VCOUNT, 7'(n));
         send_word(KIND_CLEAR, 6'd0, 6'd0);
         for (int r = 0; r < 5; r++) begin
            for (int g = $urandom_range(1, 3); g > 0; g--) send_ring(n);
            if ($urandom_range(0, 2) == 0) begin
               send_word(KIND_EDGE, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
               send_word(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 3) == 0) begin
               drain();
               write_csr(CSR_DIRECTED, 7'($urandom_range(0, 1)));
            end
            send_word(KIND_CHECK, 6'd0, 6'd0);
         end
      end
      drain();
      stim_done = 1;
   end

   // End of run: wait for the stimulus and every expected word, then report.
   initial begin
      wait (stim_done);
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
hdl/ecc_pkg.sv
hdl/ecc_req_if.sv
hdl/ecc_graph_store.sv
hdl/euler_circuit_checker_top.sv
tb/sv/tb.sv
